// ===== rtl/jtsa_pkg.sv =====
`timescale 1ns / 1ps

package jtsa_pkg;

    // accumulator rows and widths
    localparam int ROWS        = 1024;
    localparam int ROW_W       = 10;
    localparam int ADDR_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DATA_W      = 32;
    localparam int NUM_COEF    = 9;
    localparam int AXES        = 3;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_DROP   = 16;
    localparam int DOT_W       = SUM_W - FRAC_DROP;
    localparam int ACC_W       = 48;
    localparam int SAT_W       = DOT_W + 1;
    localparam int CNT_W       = 13;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 304;
    localparam int OUT_TDATA_W = AXES * ACC_W;

    localparam logic [CNT_W-1:0] SPP_RESET = CNT_W'(64);

    // round to nearest, ties up, when dropping the low product bits
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_DROP - 1);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_ACC  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_STALE = 2'd1,
        STAT_SAT   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_NOP   = 2'd0,
        KIND_STALE = 2'd1,
        KIND_ACC   = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } back_state_t;

    typedef struct packed {
        kind_t                    kind;
        logic [ROW_W-1:0]         row;
        logic signed [DOT_W-1:0]  dot_z;
        logic signed [DOT_W-1:0]  dot_y;
        logic signed [DOT_W-1:0]  dot_x;
    } q_entry_t;

endpackage

// ===== rtl/jtsa_ram.sv =====
`timescale 1ns / 1ps

module jtsa_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/jtsa_front.sv =====
`timescale 1ns / 1ps

module jtsa_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [jtsa_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [jtsa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [jtsa_pkg::OP_W-1:0]          s_axis_tuser,
    input  logic                               clear_done,
    input  logic                               q_full,
    output logic                               q_push,
    output jtsa_pkg::q_entry_t                 q_data
);

    jtsa_pkg::op_t                         in_op;
    logic [jtsa_pkg::ROW_W-1:0]            in_row;
    logic signed [jtsa_pkg::DATA_W-1:0]    in_c [jtsa_pkg::NUM_COEF];
    logic                                  row_ok;
    logic                                  stale;
    logic                                  accept;
    logic                                  adv;
    jtsa_pkg::kind_t                       kind_next;

    logic signed [jtsa_pkg::DATA_W-1:0]    vec_reg [jtsa_pkg::AXES];
    logic [jtsa_pkg::CNT_W-1:0]            count_reg;
    logic [jtsa_pkg::CNT_W-1:0]            spp_reg;

    logic                                  st1_valid_reg;
    jtsa_pkg::kind_t                       st1_kind_reg;
    logic [jtsa_pkg::ROW_W-1:0]            st1_row_reg;
    logic signed [jtsa_pkg::PROD_W-1:0]    prod_reg  [jtsa_pkg::NUM_COEF];
    logic signed [jtsa_pkg::PROD_W-1:0]    prod_next [jtsa_pkg::NUM_COEF];

    logic                                  st2_valid_reg;
    jtsa_pkg::q_entry_t                    st2_entry_reg;
    jtsa_pkg::q_entry_t                    st2_entry_next;
    logic signed [jtsa_pkg::SUM_W-1:0]     dot_sum [jtsa_pkg::AXES];

    // field unpacking
    always_comb begin
        in_op  = jtsa_pkg::op_t'(s_axis_tuser);
        in_row = s_axis_tdata[jtsa_pkg::ROW_W-1:0];
        for (int k = 0; k < jtsa_pkg::NUM_COEF; k++) begin
            in_c[k] = s_axis_tdata[jtsa_pkg::ROW_W + k*jtsa_pkg::DATA_W +: jtsa_pkg::DATA_W];
        end
    end

    // pipeline moves whenever the last stage can drain into the queue
    assign adv           = !st2_valid_reg || !q_full;
    assign s_axis_tready = adv && clear_done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // classify the item against row range and sample budget
    always_comb begin
        row_ok = (32'(in_row) < jtsa_pkg::ROWS);
        stale  = (count_reg >= spp_reg);
        case (in_op)
            jtsa_pkg::OP_ACC: begin
                if (!row_ok) begin
                    kind_next = jtsa_pkg::KIND_NOP;
                end else if (stale) begin
                    kind_next = jtsa_pkg::KIND_STALE;
                end else begin
                    kind_next = jtsa_pkg::KIND_ACC;
                end
            end
            jtsa_pkg::OP_READ: begin
                kind_next = row_ok ? jtsa_pkg::KIND_READ : jtsa_pkg::KIND_NOP;
            end
            default: begin
                kind_next = jtsa_pkg::KIND_NOP;
            end
        endcase
    end

    // nine products J(t,a) * v(t), indexed axis-major
    always_comb begin
        for (int a = 0; a < jtsa_pkg::AXES; a++) begin
            for (int t = 0; t < jtsa_pkg::AXES; t++) begin
                prod_next[a*jtsa_pkg::AXES + t] = in_c[a + jtsa_pkg::AXES*t] * vec_reg[t];
            end
        end
    end

    // exact sum of three products, then round to q34.16
    always_comb begin
        for (int a = 0; a < jtsa_pkg::AXES; a++) begin
            dot_sum[a] = jtsa_pkg::SUM_W'(prod_reg[a*jtsa_pkg::AXES])
                       + jtsa_pkg::SUM_W'(prod_reg[a*jtsa_pkg::AXES + 1])
                       + jtsa_pkg::SUM_W'(prod_reg[a*jtsa_pkg::AXES + 2])
                       + jtsa_pkg::ROUND_BIAS;
        end
        st2_entry_next.kind  = st1_kind_reg;
        st2_entry_next.row   = st1_row_reg;
        st2_entry_next.dot_x = dot_sum[0][jtsa_pkg::SUM_W-1:jtsa_pkg::FRAC_DROP];
        st2_entry_next.dot_y = dot_sum[1][jtsa_pkg::SUM_W-1:jtsa_pkg::FRAC_DROP];
        st2_entry_next.dot_z = dot_sum[2][jtsa_pkg::SUM_W-1:jtsa_pkg::FRAC_DROP];
    end

    // point vector, sample counter and budget register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < jtsa_pkg::AXES; t++) begin
                vec_reg[t] <= '0;
            end
            count_reg <= '0;
            spp_reg   <= jtsa_pkg::SPP_RESET;
        end else begin
            if (cfg_wr_en) begin
                spp_reg <= cfg_wr_data;
            end
            if (accept && in_op == jtsa_pkg::OP_LOAD) begin
                for (int t = 0; t < jtsa_pkg::AXES; t++) begin
                    vec_reg[t] <= in_c[t];
                end
                count_reg <= '0;
            end else if (accept && kind_next == jtsa_pkg::KIND_ACC) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= accept;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_kind_reg  <= kind_next;
            st1_row_reg   <= in_row;
            prod_reg      <= prod_next;
            st2_entry_reg <= st2_entry_next;
        end
    end

    assign q_push = st2_valid_reg && !q_full;
    assign q_data = st2_entry_reg;

endmodule

// ===== rtl/jtsa_queue.sv =====
`timescale 1ns / 1ps

module jtsa_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  jtsa_pkg::q_entry_t  push_data,
    output logic                full,
    input  logic                pop,
    output jtsa_pkg::q_entry_t  pop_data,
    output logic                valid
);

    jtsa_pkg::q_entry_t              slot_reg [jtsa_pkg::Q_DEPTH];
    logic [jtsa_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [jtsa_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [jtsa_pkg::Q_PTR_W:0]      cnt_reg;

    assign full     = (cnt_reg == (jtsa_pkg::Q_PTR_W+1)'(jtsa_pkg::Q_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("queue pushed while full");

endmodule

// ===== rtl/jtsa_back.sv =====
`timescale 1ns / 1ps

module jtsa_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  jtsa_pkg::q_entry_t                 q_data,
    output logic                               q_pop,
    output logic                               clear_done,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [jtsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [jtsa_pkg::STAT_W-1:0]        m_axis_tuser
);

    jtsa_pkg::back_state_t                 state_reg, state_next;
    logic [jtsa_pkg::ADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    jtsa_pkg::q_entry_t                    cur_reg, cur_next;

    logic                                  m_valid_reg;
    logic [jtsa_pkg::OUT_TDATA_W-1:0]      m_data_reg, m_data_next;
    jtsa_pkg::status_t                     m_stat_reg, m_stat_next;
    logic                                  load_out;
    logic                                  out_free;

    logic                                  rd_en;
    logic [jtsa_pkg::ADDR_W-1:0]           rd_addr;
    logic [jtsa_pkg::OUT_TDATA_W-1:0]      rd_data;
    logic                                  wr_en;
    logic [jtsa_pkg::ADDR_W-1:0]           wr_addr;
    logic [jtsa_pkg::OUT_TDATA_W-1:0]      wr_data;

    logic [jtsa_pkg::ACC_W:0]              sat_x, sat_y, sat_z;
    logic                                  any_sat;

    // add with saturation to the accumulator range, flag in the top bit
    function automatic logic [jtsa_pkg::ACC_W:0] sat_add(
        input logic signed [jtsa_pkg::ACC_W-1:0] acc,
        input logic signed [jtsa_pkg::DOT_W-1:0] dot
    );
        logic signed [jtsa_pkg::SAT_W-1:0]          s;
        logic [jtsa_pkg::SAT_W-jtsa_pkg::ACC_W:0]   hi;
        s  = jtsa_pkg::SAT_W'(acc) + jtsa_pkg::SAT_W'(dot);
        hi = s[jtsa_pkg::SAT_W-1:jtsa_pkg::ACC_W-1];
        if ((&hi) || !(|hi)) begin
            return {1'b0, s[jtsa_pkg::ACC_W-1:0]};
        end else if (s[jtsa_pkg::SAT_W-1]) begin
            return {1'b1, jtsa_pkg::ACC_MIN};
        end else begin
            return {1'b1, jtsa_pkg::ACC_MAX};
        end
    endfunction

    jtsa_ram #(
        .WIDTH (jtsa_pkg::OUT_TDATA_W),
        .DEPTH (jtsa_pkg::ROWS)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free   = !m_valid_reg || m_axis_tready;
    assign clear_done = (state_reg != jtsa_pkg::ST_CLEAR);
    assign rd_addr    = jtsa_pkg::ADDR_W'(q_data.row);

    // accumulate the three dot products into the row read back
    always_comb begin
        sat_x   = sat_add(rd_data[0*jtsa_pkg::ACC_W +: jtsa_pkg::ACC_W], cur_reg.dot_x);
        sat_y   = sat_add(rd_data[1*jtsa_pkg::ACC_W +: jtsa_pkg::ACC_W], cur_reg.dot_y);
        sat_z   = sat_add(rd_data[2*jtsa_pkg::ACC_W +: jtsa_pkg::ACC_W], cur_reg.dot_z);
        any_sat = sat_x[jtsa_pkg::ACC_W] || sat_y[jtsa_pkg::ACC_W] || sat_z[jtsa_pkg::ACC_W];
    end

    // sequencer: clearing pass, then per item a read-modify-write of its row or a direct result
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cur_next      = cur_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = clr_addr_reg;
        wr_data       = '0;
        load_out      = 1'b0;
        m_data_next   = '0;
        m_stat_next   = jtsa_pkg::STAT_OK;
        case (state_reg)
            jtsa_pkg::ST_CLEAR: begin
                wr_en         = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == jtsa_pkg::ADDR_W'(jtsa_pkg::ROWS - 1)) begin
                    state_next = jtsa_pkg::ST_IDLE;
                end
            end
            jtsa_pkg::ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    if (q_data.kind == jtsa_pkg::KIND_ACC ||
                        q_data.kind == jtsa_pkg::KIND_READ) begin
                        rd_en      = 1'b1;
                        state_next = jtsa_pkg::ST_EXEC;
                    end else begin
                        load_out = 1'b1;
                        if (q_data.kind == jtsa_pkg::KIND_STALE) begin
                            m_stat_next = jtsa_pkg::STAT_STALE;
                        end
                    end
                end
            end
            jtsa_pkg::ST_EXEC: begin
                wr_en      = 1'b1;
                wr_addr    = jtsa_pkg::ADDR_W'(cur_reg.row);
                load_out   = 1'b1;
                state_next = jtsa_pkg::ST_IDLE;
                if (cur_reg.kind == jtsa_pkg::KIND_READ) begin
                    m_data_next = rd_data;
                end else begin
                    wr_data = {sat_z[jtsa_pkg::ACC_W-1:0], sat_y[jtsa_pkg::ACC_W-1:0],
                               sat_x[jtsa_pkg::ACC_W-1:0]};
                    if (any_sat) begin
                        m_stat_next = jtsa_pkg::STAT_SAT;
                    end
                end
            end
            default: begin
                state_next = jtsa_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= jtsa_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // current item and output payload
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (load_out) begin
            m_data_reg <= m_data_next;
            m_stat_reg <= m_stat_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_stat_reg;

    a_exec_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == jtsa_pkg::ST_EXEC |=> state_reg == jtsa_pkg::ST_IDLE)
        else $error("read-modify-write took more than one cycle");

    a_read_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> state_reg == jtsa_pkg::ST_EXEC && $past(q_pop))
        else $error("ram read without a popped item");

    a_quiet_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == jtsa_pkg::ST_CLEAR |-> !q_pop && !m_valid_reg)
        else $error("item handled during clearing pass");

    a_stale_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_stat_reg != jtsa_pkg::STAT_OK |-> m_data_reg == '0)
        else $error("flagged item carries nonzero sums");

endmodule

// ===== rtl/jacobian_transpose_scatter_accumulate_core.sv =====
`timescale 1ns / 1ps

// Transposed-Jacobian scatter accumulator. A load item (tuser 0) latches the
// residual vector from c1..c3; a sample item (tuser 1) adds J^T * v, rounded
// to Q34.16, into the three saturating 48-bit sums of its row; a read item
// (tuser 2) returns the row's sums and clears it. Every item gives exactly
// one result item, in order. After reset the accumulator RAM is cleared one
// row per cycle, and s_axis_tready stays low until all ROWS (1024) rows are
// cleared. The front end takes one item per cycle, unless the queue is full
// and its last stage is held, into a two-stage multiply/round pipeline
// feeding a four-entry queue; the back end handles sample and read items as
// a registered read of the accumulator RAM followed by a write back, the
// others directly, and it takes no new item until that write back is done.
module jacobian_transpose_scatter_accumulate_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [jtsa_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // row_index[9:0], c1..c9 32 bits each from bit 10 up, zero fill to 304
    input  logic [jtsa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op[1:0]
    input  logic [jtsa_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // sum_x[47:0], sum_y[95:48], sum_z[143:96]
    output logic [jtsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // status[1:0]
    output logic [jtsa_pkg::STAT_W-1:0]        m_axis_tuser
);

    logic                  clear_done;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    jtsa_pkg::q_entry_t    q_in;
    jtsa_pkg::q_entry_t    q_out;

    // classify items and form the rounded dot products
    jtsa_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .clear_done    (clear_done),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    // decoupling queue
    jtsa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    // accumulator RAM and result register
    jtsa_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .clear_done    (clear_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import jtsa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int COEF_BITS = NUM_COEF * DATA_W;

    typedef logic [NUM_COEF-1:0][DATA_W-1:0] coef_vec_t;

    // one item waiting to go out on the input stream
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        coef_vec_t        coef;
    } jt_item_t;

    // one expected result item
    typedef struct {
        logic [ACC_W-1:0] sx;
        logic [ACC_W-1:0] sy;
        logic [ACC_W-1:0] sz;
        status_t          status;
    } row_sums_t;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0]       cfg_wr_data   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // row_index, c1..c9, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // op
    logic [OP_W-1:0]        s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // sum_x, sum_y, sum_z
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // status
    logic [STAT_W-1:0]      m_axis_tuser;

    jacobian_transpose_scatter_accumulate_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    jt_item_t  items_to_send[$];
    row_sums_t expected_sums[$];
    jt_item_t  next_item;
    row_sums_t want;
    logic      item_taken   = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        errors        = 0;
    logic      bad;

    // shadow copy of the block state
    logic signed [ACC_W-1:0]  acc_x_m [ROWS];
    logic signed [ACC_W-1:0]  acc_y_m [ROWS];
    logic signed [ACC_W-1:0]  acc_z_m [ROWS];
    logic signed [DATA_W-1:0] vec_x, vec_y, vec_z;
    logic [CNT_W-1:0]         samples_used;
    logic [CNT_W-1:0]         samples_allowed;

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #2400000;
        $display("simulation failed");
        $finish;
    end

    // a*x + b*y + c*z of the latched vector, rounded to q34.16, ties up
    function automatic logic signed [DOT_W-1:0] rounded_dot(logic signed [DATA_W-1:0] a,
                                                          logic signed [DATA_W-1:0] b,
                                                          logic signed [DATA_W-1:0] c);
        longint                  pa, pb, pc;
        logic signed [SUM_W-1:0] s;
        pa = longint'(a) * longint'(vec_x);
        pb = longint'(b) * longint'(vec_y);
        pc = longint'(c) * longint'(vec_z);
        s = SUM_W'(pa) + SUM_W'(pb) + SUM_W'(pc);
        s = s + (SUM_W'(1) <<< (FRAC_DROP - 1));
        s = s >>> FRAC_DROP;
        return s[DOT_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] acc,
                                                        logic signed [DOT_W-1:0] d,
                                                        inout logic sat);
        logic signed [DOT_W:0] t;
        t = (DOT_W+1)'(acc) + (DOT_W+1)'(d);
        if (t > (DOT_W+1)'(ACC_MAX)) begin
            sat = 1'b1;
            return ACC_MAX;
        end
        if (t < (DOT_W+1)'(ACC_MIN)) begin
            sat = 1'b1;
            return ACC_MIN;
        end
        return t[ACC_W-1:0];
    endfunction

    // update the shadow state for one accepted item and queue its result
    function automatic void predict_item(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                         coef_vec_t c);
        row_sums_t r;
        logic      sat;
        r.sx = '0;
        r.sy = '0;
        r.sz = '0;
        r.status = STAT_OK;
        if (op == OP_LOAD) begin
            vec_x = c[0];
            vec_y = c[1];
            vec_z = c[2];
            samples_used = '0;
        end else if (op == OP_ACC && 32'(row) < ROWS) begin
            if (samples_used >= samples_allowed) begin
                r.status = STAT_STALE;
            end else begin
                sat = 1'b0;
                acc_x_m[row] = sat_add(acc_x_m[row], rounded_dot(c[0], c[3], c[6]), sat);
                acc_y_m[row] = sat_add(acc_y_m[row], rounded_dot(c[1], c[4], c[7]), sat);
                acc_z_m[row] = sat_add(acc_z_m[row], rounded_dot(c[2], c[5], c[8]), sat);
                samples_used = samples_used + 1'b1;
                if (sat) begin
                    r.status = STAT_SAT;
                end
            end
        end else if (op == OP_READ && 32'(row) < ROWS) begin
            r.sx = acc_x_m[row];
            r.sy = acc_y_m[row];
            r.sz = acc_z_m[row];
            acc_x_m[row] = '0;
            acc_y_m[row] = '0;
            acc_z_m[row] = '0;
        end
        expected_sums.push_back(r);
    endfunction

    // mix of full range, small, extreme and unit-scale q16.16 words
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(524288) - 32'd262144;
            2: begin
                case ($urandom_range(4))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return $urandom_range(131072) - 32'd65536;
        endcase
    endfunction

    function automatic coef_vec_t rand_coefs();
        coef_vec_t c;
        for (int k = 0; k < NUM_COEF; k++) begin
            c[k] = rand_word();
        end
        return c;
    endfunction

    // mostly a few hot rows so reads see accumulated sums
    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(99) < 85) begin
            return ROW_W'($urandom_range(7));
        end
        return ROW_W'($urandom_range(ROWS - 1));
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                        input coef_vec_t coef);
        jt_item_t it;
        it.op = op;
        it.row = row;
        it.coef = coef;
        items_to_send.push_back(it);
    endtask

    task automatic load_vector(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                               input logic [DATA_W-1:0] z);
        coef_vec_t c;
        c = rand_coefs();
        c[0] = x;
        c[1] = y;
        c[2] = z;
        send(OP_LOAD, ROW_W'($urandom_range(ROWS - 1)), c);
    endtask

    task automatic write_spp(input logic [CNT_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        samples_allowed = v;
    endtask

    // wait until every item is sent and every result is back
    task automatic drain();
        while (items_to_send.size() != 0 || s_axis_tvalid || expected_sums.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    // load/sample/read runs with random content, plus some noise
    task automatic random_phase(input int n);
        int added;
        int k;
        added = 0;
        while (added < n) begin
            if ($urandom_range(99) < 80) begin
                load_vector(rand_word(), rand_word(), rand_word());
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++) begin
                    send(OP_ACC, pick_row(), rand_coefs());
                end
                added += k + 1;
                if ($urandom_range(1) == 1) begin
                    send(OP_READ, pick_row(), rand_coefs());
                    added++;
                end
            end else begin
                send(OP_W'($urandom_range(3)), ROW_W'($urandom_range(ROWS - 1)),
                     rand_coefs());
                added++;
            end
        end
    endtask

    // input handshake: note the accepted item and predict its result
    always @(posedge aclk) begin
        item_taken = aresetn && s_axis_tvalid && s_axis_tready;
        if (item_taken) begin
            predict_item(s_axis_tuser, s_axis_tdata[ROW_W-1:0],
                         s_axis_tdata[ROW_W+COEF_BITS-1:ROW_W]);
        end
    end

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || item_taken) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = items_to_send.pop_front();
                s_axis_tdata <= IN_TDATA_W'({next_item.coef, next_item.row});
                s_axis_tuser <= next_item.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_sums.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result item: x=%h y=%h z=%h status=%0d",
                             m_axis_tdata[ACC_W-1:0], m_axis_tdata[2*ACC_W-1:ACC_W],
                             m_axis_tdata[3*ACC_W-1:2*ACC_W], m_axis_tuser);
                end
            end else begin
                want = expected_sums.pop_front();
                bad = (m_axis_tdata[ACC_W-1:0] !== want.sx)
                   || (m_axis_tdata[2*ACC_W-1:ACC_W] !== want.sy)
                   || (m_axis_tdata[3*ACC_W-1:2*ACC_W] !== want.sz)
                   || (m_axis_tuser !== want.status);
                if (bad) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at %0t: exp x=%h y=%h z=%h status=%0d",
                                 $realtime, want.sx, want.sy, want.sz, want.status);
                        $display("                 got x=%h y=%h z=%h status=%0d",
                                 m_axis_tdata[ACC_W-1:0], m_axis_tdata[2*ACC_W-1:ACC_W],
                                 m_axis_tdata[3*ACC_W-1:2*ACC_W], m_axis_tuser);
                    end
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        for (int i = 0; i < ROWS; i++) begin
            acc_x_m[i] = '0;
            acc_y_m[i] = '0;
            acc_z_m[i] = '0;
        end
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        samples_used = '0;
        samples_allowed = SPP_RESET;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 64;
        write_spp(CNT_W'(1));

        // empty read, sample on the reset vector, then a stale sample
        send(OP_READ, ROW_W'(0), '0);
        send(OP_ACC, ROW_W'(3), rand_coefs());
        send(OP_ACC, ROW_W'(3), rand_coefs());
        // positive saturation on the top row
        load_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(OP_ACC, 10'h3ff, {NUM_COEF{32'h8000_0000}});
        send(OP_ACC, 10'h3ff, {NUM_COEF{32'h8000_0000}});
        send(OP_READ, 10'h3ff, '0);
        // negative saturation
        load_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send(OP_ACC, 10'h3fe, {NUM_COEF{32'h8000_0000}});
        send(OP_READ, 10'h3fe, '0);
        // unused op with every row and coefficient bit high
        send(OP_UNUSED, 10'h3ff, {NUM_COEF{32'hffff_ffff}});
        // rounding ties: +0.5 goes up, -0.5 goes to zero, just under half drops
        load_vector(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000);
        send(OP_ACC, ROW_W'(5), {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                 32'h0000_7fff, 32'h0, 32'h0000_8000});
        load_vector(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000);
        send(OP_ACC, ROW_W'(6), {32'h0, 32'h0, 32'h0, 32'h0, 32'h8000, 32'h0,
                                 32'h0, 32'h0, 32'h0});
        send(OP_READ, ROW_W'(5), '0);
        send(OP_READ, ROW_W'(6), '0);
        drain();

        // zero samples per vector: every sample is stale
        write_spp(CNT_W'(0));
        load_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send(OP_ACC, ROW_W'(2), rand_coefs());
        send(OP_READ, ROW_W'(2), '0);
        drain();

        write_spp(CNT_W'(5));
        random_phase(170);
        drain();

        send_idle_pct = 64;
        recv_idle_pct = 9;
        write_spp(CNT_W'(4096));
        random_phase(170);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_spp(CNT_W'(2));
        random_phase(170);
        drain();

        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_sums.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/jtsa_pkg.sv
rtl/jtsa_ram.sv
rtl/jtsa_front.sv
rtl/jtsa_queue.sv
rtl/jtsa_back.sv
rtl/jacobian_transpose_scatter_accumulate_core.sv
tb/sv/tb_top.sv
